/* rtl/core/c8ie_pkg.sv */
// ----------------------------------------------------------------------------
// c8ie_pkg
// Shared types and constants for the CHIP-8 instruction execute block.
// ----------------------------------------------------------------------------
package c8ie_pkg;

    localparam int MEM_BYTES_DEF   = 4096;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int SCREEN_W        = 64;
    localparam int SCREEN_H        = 32;
    localparam int PC_RESET        = 512;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_EXEC = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;
    localparam logic [1:0] KIND_READ = 2'd3;

    // datapath commands
    localparam logic [3:0] CMD_NONE   = 4'd0;
    localparam logic [3:0] CMD_LOAD   = 4'd1;  // latch item, decode
    localparam logic [3:0] CMD_EXEC   = 4'd2;  // simple ops
    localparam logic [3:0] CMD_CLS    = 4'd3;  // clear one row
    localparam logic [3:0] CMD_DRAW_A = 4'd4;  // issue sprite byte read
    localparam logic [3:0] CMD_DRAW_B = 4'd5;  // rmw one row
    localparam logic [3:0] CMD_ST     = 4'd6;  // store one byte (55/33/mem load)
    localparam logic [3:0] CMD_LD_A   = 4'd7;  // issue read for 65
    localparam logic [3:0] CMD_LD_B   = 4'd8;  // write vreg for 65
    localparam logic [3:0] CMD_RET_A  = 4'd9;  // issue stack read
    localparam logic [3:0] CMD_RET_B  = 4'd10; // take stack data
    localparam logic [3:0] CMD_DONE   = 4'd11; // drive result

    // operation classes from decode
    localparam logic [2:0] OP_SIMPLE = 3'd0;
    localparam logic [2:0] OP_CLS    = 3'd1;
    localparam logic [2:0] OP_DRAW   = 3'd2;
    localparam logic [2:0] OP_STORE  = 3'd3;
    localparam logic [2:0] OP_LOADV  = 3'd4;
    localparam logic [2:0] OP_RET    = 3'd5;

    typedef struct packed {
        logic [3:0] cmd;
    } t_ctl;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] count;  // steps for multi-step ops
        logic [4:0] step;   // current step index
    } t_stat;

endpackage

/* rtl/core/chip8_instruction_execute.sv */
// ----------------------------------------------------------------------------
// chip8_instruction_execute
// Items: simple ops, return, N-row draw or FX65, N-byte store (FX33, FX55,
// memory load) and clear screen, each stepped by the sequencer.
// One item at a time, next accepted in the strobe cycle; o_done lasts
// one cycle and cannot be stalled. Synchronous active-low reset clears state.
// ----------------------------------------------------------------------------
module chip8_instruction_execute #(
    parameter int MEM_BYTES   = c8ie_pkg::MEM_BYTES_DEF,
    parameter int STACK_DEPTH = c8ie_pkg::STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_opcode,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [15:0] i_key_mask,
    input  logic [3:0]  i_waited_key,
    input  logic [7:0]  i_random_byte,
    input  logic [4:0]  i_row_index,
    output logic        o_done,
    output logic        o_status,
    output logic [15:0] o_next_pc,
    output logic [15:0] o_index_value,
    output logic [7:0]  o_flag_value,
    output logic        o_sound_on,
    output logic [63:0] o_display_row
);
    import c8ie_pkg::*;

    t_ctl       ctl;
    t_stat      stat;
    logic [4:0] step;

    c8ie_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .o_busy (busy),
        .i_stat (stat),
        .o_ctl  (ctl),
        .o_step (step)
    );

    c8ie_dp #(
        .MEM_BYTES  (MEM_BYTES),
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_step       (step),
        .o_stat       (stat),
        .i_kind       (i_kind),
        .i_opcode     (i_opcode),
        .i_address    (i_address),
        .i_data       (i_data),
        .i_key_mask   (i_key_mask),
        .i_waited_key (i_waited_key),
        .i_random_byte(i_random_byte),
        .i_row_index  (i_row_index),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_next_pc    (o_next_pc),
        .o_index_value(o_index_value),
        .o_flag_value (o_flag_value),
        .o_sound_on   (o_sound_on),
        .o_display_row(o_display_row)
    );

`ifndef ASSERT_OFF
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("done while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("item not taken");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("double result");
`endif

endmodule

/* rtl/core/c8ie_ctrl.sv */
// ----------------------------------------------------------------------------
// c8ie_ctrl
// Sequencer: steps the datapath through each item.
// ----------------------------------------------------------------------------
module c8ie_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  c8ie_pkg::t_stat i_stat,
    output c8ie_pkg::t_ctl  o_ctl,
    output logic [4:0]      o_step
);
    import c8ie_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_A    = 3'd2;
    localparam logic [2:0] S_B    = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state, n_state;
    logic [4:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_step = r_step;

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        o_ctl.cmd = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.cmd = CMD_LOAD;
                    n_state   = S_DEC;
                    n_step    = '0;
                end
            end
            S_DEC: begin
                case (i_stat.op)
                    OP_SIMPLE: begin
                        o_ctl.cmd = CMD_EXEC;
                        n_state   = S_DONE;
                    end
                    OP_RET: begin
                        o_ctl.cmd = CMD_RET_A;
                        n_state   = S_B;
                    end
                    default: begin
                        if (i_stat.count == 5'd0) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_A;
                        end
                    end
                endcase
            end
            S_A: begin
                case (i_stat.op)
                    OP_CLS: o_ctl.cmd = CMD_CLS;
                    OP_STORE: o_ctl.cmd = CMD_ST;
                    OP_DRAW: o_ctl.cmd = CMD_DRAW_A;
                    default: o_ctl.cmd = CMD_LD_A;
                endcase
                if (i_stat.op == OP_CLS || i_stat.op == OP_STORE) begin
                    n_step = r_step + 5'd1;
                    if (r_step + 5'd1 == i_stat.count) begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_B;
                end
            end
            S_B: begin
                case (i_stat.op)
                    OP_DRAW: o_ctl.cmd = CMD_DRAW_B;
                    OP_RET: o_ctl.cmd = CMD_RET_B;
                    default: o_ctl.cmd = CMD_LD_B;
                endcase
                n_step  = r_step + 5'd1;
                n_state = S_A;
                if (i_stat.op == OP_RET || r_step + 5'd1 == i_stat.count) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_ctl.cmd = CMD_DONE;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/core/c8ie_dp.sv */
// ----------------------------------------------------------------------------
// c8ie_dp
// Datapath: machine state, memories and the instruction ALU.
// ----------------------------------------------------------------------------
module c8ie_dp #(
    parameter int MEM_BYTES   = c8ie_pkg::MEM_BYTES_DEF,
    parameter int STACK_DEPTH = c8ie_pkg::STACK_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  c8ie_pkg::t_ctl  i_ctl,
    input  logic [4:0]      i_step,
    output c8ie_pkg::t_stat o_stat,
    input  logic [1:0]      i_kind,
    input  logic [15:0]     i_opcode,
    input  logic [11:0]     i_address,
    input  logic [7:0]      i_data,
    input  logic [15:0]     i_key_mask,
    input  logic [3:0]      i_waited_key,
    input  logic [7:0]      i_random_byte,
    input  logic [4:0]      i_row_index,
    output logic            o_done,
    output logic            o_status,
    output logic [15:0]     o_next_pc,
    output logic [15:0]     o_index_value,
    output logic [7:0]      o_flag_value,
    output logic            o_sound_on,
    output logic [63:0]     o_display_row
);
    import c8ie_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam int SW = $clog2(STACK_DEPTH);

    logic [7:0]  r_v [16];
    logic [15:0] r_pc, r_i;
    logic [SW-1:0] r_sp;
    logic [7:0]  r_dt, r_st;
    logic [63:0] r_fb [SCREEN_H];
    logic [7:0]  r_mem [MEM_BYTES];
    logic [15:0] r_stk [STACK_DEPTH];
    logic [7:0]  r_mrd;
    logic [15:0] r_srd;

    logic [1:0]  r_kind;
    logic [15:0] r_op, r_keys;
    logic [11:0] r_addr;
    logic [7:0]  r_data, r_rnd;
    logic [3:0]  r_wkey;
    logic [4:0]  r_row;
    logic [7:0]  r_vx, r_vy;
    logic        r_unk;
    logic [2:0]  r_cls;
    logic [4:0]  r_cnt;

    logic [3:0] x, n;
    logic [7:0] nn;
    assign x  = r_op[11:8];
    assign n  = r_op[3:0];
    assign nn = r_op[7:0];

    assign o_stat.op    = r_cls;
    assign o_stat.count = r_cnt;
    assign o_stat.step  = i_step;

    // stack pointer wraps at STACK_DEPTH
    logic [SW-1:0] sp_up, sp_dn;
    assign sp_up = (r_sp == SW'(STACK_DEPTH - 1)) ? '0 : r_sp + SW'(1);
    assign sp_dn = (r_sp == '0) ? SW'(STACK_DEPTH - 1) : r_sp - SW'(1);

    // decode of the incoming item, latched on load
    logic [2:0] d_cls;
    logic [4:0] d_cnt;
    logic       d_unk;
    always_comb begin
        d_cls = OP_SIMPLE;
        d_cnt = '0;
        d_unk = 1'b0;
        if (i_kind == KIND_LOAD) begin
            d_cls = OP_STORE;
            d_cnt = 5'd1;
        end else if (i_kind == KIND_EXEC) begin
            case (i_opcode[15:12])
                4'h0: begin
                    if (i_opcode == 16'h00E0) begin
                        d_cls = OP_CLS;
                        d_cnt = 5'(SCREEN_H - 1);
                    end else if (i_opcode == 16'h00EE) begin
                        d_cls = OP_RET;
                    end else begin
                        d_unk = 1'b1;
                    end
                end
                4'h8: d_unk = !(i_opcode[3:0] <= 4'h7 || i_opcode[3:0] == 4'hE);
                4'hD: begin
                    d_cls = OP_DRAW;
                    d_cnt = {1'b0, i_opcode[3:0]};
                end
                4'hE: d_unk = !(i_opcode[7:0] == 8'h9E || i_opcode[7:0] == 8'hA1);
                4'hF: begin
                    case (i_opcode[7:0])
                        8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29: ;
                        8'h33: begin
                            d_cls = OP_STORE;
                            d_cnt = 5'd3;
                        end
                        8'h55: begin
                            d_cls = OP_STORE;
                            d_cnt = {1'b0, i_opcode[11:8]} + 5'd1;
                        end
                        8'h65: begin
                            d_cls = OP_LOADV;
                            d_cnt = {1'b0, i_opcode[11:8]} + 5'd1;
                        end
                        default: d_unk = 1'b1;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // FX33 digits by compare and subtract
    logic [1:0] bcd_h;
    logic [6:0] bcd_r;
    logic [3:0] bcd_t, bcd_o;
    always_comb begin
        if (r_vx >= 8'd200) begin
            bcd_h = 2'd2;
            bcd_r = 7'(r_vx - 8'd200);
        end else if (r_vx >= 8'd100) begin
            bcd_h = 2'd1;
            bcd_r = 7'(r_vx - 8'd100);
        end else begin
            bcd_h = 2'd0;
            bcd_r = r_vx[6:0];
        end
        bcd_t = '0;
        for (int k = 1; k < 10; k++) begin
            if (bcd_r >= 7'(10 * k)) bcd_t = 4'(k);
        end
        bcd_o = 4'(bcd_r - {3'd0, bcd_t} * 7'd10);
    end

    // store-step address and data
    logic [15:0] st_addr;
    logic [7:0]  st_data;
    always_comb begin
        if (r_kind == KIND_LOAD) begin
            st_addr = {4'd0, r_addr};
            st_data = r_data;
        end else if (nn == 8'h33) begin
            st_addr = r_i + {11'd0, i_step};
            case (i_step[1:0])
                2'd0: st_data = {6'd0, bcd_h};
                2'd1: st_data = {4'd0, bcd_t};
                default: st_data = {4'd0, bcd_o};
            endcase
        end else begin
            st_addr = r_i + {11'd0, i_step};
            st_data = r_v[i_step[3:0]];
        end
    end

    logic [15:0] rd_addr;
    assign rd_addr = r_i + {11'd0, i_step};

    // sprite row
    logic [63:0] spr, spr_rot;
    logic [4:0]  drow;
    assign spr     = {r_mrd, 56'd0};
    assign spr_rot = (spr >> r_vx[5:0]) | (spr << (7'd64 - {1'b0, r_vx[5:0]}));
    assign drow    = r_vy[4:0] + i_step[4:0];

    logic press;
    assign press = (r_vx < 8'd16) && r_keys[r_vx[3:0]];

    logic [8:0] sum;
    assign sum = {1'b0, r_vx} + {1'b0, r_vy};

    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            CMD_ST: r_mem[st_addr[AW-1:0]] <= st_data;
            default: ;
        endcase
        r_mrd <= r_mem[rd_addr[AW-1:0]];
        if (i_ctl.cmd == CMD_EXEC && r_kind == KIND_EXEC && r_op[15:12] == 4'h2) begin
            r_stk[r_sp] <= r_pc;
        end
        r_srd <= r_stk[sp_dn];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
            for (int k = 0; k < SCREEN_H; k++) r_fb[k] <= '0;
            r_pc   <= 16'(PC_RESET);
            r_i    <= '0;
            r_sp   <= '0;
            r_dt   <= '0;
            r_st   <= '0;
            r_cls  <= OP_SIMPLE;
            r_cnt  <= '0;
            r_unk  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (i_ctl.cmd)
                CMD_LOAD: begin
                    r_kind <= i_kind;
                    r_op   <= i_opcode;
                    r_addr <= i_address;
                    r_data <= i_data;
                    r_keys <= i_key_mask;
                    r_wkey <= i_waited_key;
                    r_rnd  <= i_random_byte;
                    r_row  <= i_row_index;
                    r_vx   <= r_v[i_opcode[11:8]];
                    r_vy   <= r_v[i_opcode[7:4]];
                    r_cls  <= d_cls;
                    r_cnt  <= d_cnt;
                    r_unk  <= d_unk;
                    if (i_kind == KIND_EXEC) r_pc <= r_pc + 16'd2;
                    if (i_kind == KIND_TICK) begin
                        if (r_dt != 0) r_dt <= r_dt - 8'd1;
                        if (r_st != 0) r_st <= r_st - 8'd1;
                    end
                    if (i_kind == KIND_EXEC && i_opcode[15:12] == 4'hD) r_v[15] <= '0;
                end
                CMD_EXEC: if (r_kind == KIND_EXEC && !r_unk) begin
                    case (r_op[15:12])
                        4'h1: r_pc <= {4'd0, r_op[11:0]};
                        4'h2: begin
                            r_sp <= sp_up;
                            r_pc <= {4'd0, r_op[11:0]};
                        end
                        4'h3: if (r_vx == nn) r_pc <= r_pc + 16'd2;
                        4'h4: if (r_vx != nn) r_pc <= r_pc + 16'd2;
                        4'h5: if (r_vx == r_vy) r_pc <= r_pc + 16'd2;
                        4'h6: r_v[x] <= nn;
                        4'h7: r_v[x] <= r_vx + nn;
                        4'h8: begin
                            case (n)
                                4'h0: r_v[x] <= r_vy;
                                4'h1: r_v[x] <= r_vx | r_vy;
                                4'h2: r_v[x] <= r_vx & r_vy;
                                4'h3: r_v[x] <= r_vx ^ r_vy;
                                4'h4: begin
                                    r_v[15] <= {7'd0, sum[8]};
                                    r_v[x]  <= sum[7:0];
                                end
                                4'h5: begin
                                    r_v[15] <= {7'd0, r_vx >= r_vy};
                                    r_v[x]  <= r_vx - r_vy;
                                end
                                4'h6: begin
                                    r_v[15] <= {7'd0, r_vx[0]};
                                    r_v[x]  <= r_vx >> 1;
                                end
                                4'h7: begin
                                    r_v[15] <= {7'd0, r_vy >= r_vx};
                                    r_v[x]  <= r_vy - r_vx;
                                end
                                default: begin
                                    r_v[15] <= {7'd0, r_vx[7]};
                                    r_v[x]  <= r_vx << 1;
                                end
                            endcase
                        end
                        4'h9: if (r_vx != r_vy) r_pc <= r_pc + 16'd2;
                        4'hA: r_i <= {4'd0, r_op[11:0]};
                        4'hB: r_pc <= {4'd0, r_op[11:0]} + {8'd0, r_v[0]};
                        4'hC: r_v[x] <= r_rnd & nn;
                        4'hE: begin
                            if ((nn == 8'h9E) == press) r_pc <= r_pc + 16'd2;
                        end
                        4'hF: begin
                            case (nn)
                                8'h07: r_v[x] <= r_dt;
                                8'h0A: r_v[x] <= {4'd0, r_wkey};
                                8'h15: r_dt <= r_vx;
                                8'h18: r_st <= r_vx;
                                8'h1E: r_i <= r_i + {8'd0, r_vx};
                                default: r_i <= {8'd0, r_vx} * 16'd5;
                            endcase
                        end
                        default: ;
                    endcase
                end
                CMD_CLS: begin
                    r_fb[i_step] <= '0;
                    if (i_step == 5'(SCREEN_H - 2)) r_fb[SCREEN_H-1] <= '0;
                end
                CMD_DRAW_B: begin
                    if ((r_fb[drow] & spr_rot) != 0) r_v[15] <= 8'd1;
                    r_fb[drow] <= r_fb[drow] ^ spr_rot;
                end
                CMD_LD_B: r_v[i_step[3:0]] <= r_mrd;
                CMD_RET_A: r_sp <= sp_dn;
                CMD_RET_B: r_pc <= r_srd;
                CMD_DONE: o_done <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_status      = r_unk;
    assign o_next_pc     = r_pc;
    assign o_index_value = r_i;
    assign o_flag_value  = r_v[15];
    assign o_sound_on    = (r_st != 0);
    assign o_display_row = r_fb[r_row];

endmodule

/* sim/chip8_instruction_execute_tb.sv */
// ----------------------------------------------------------------------------
// chip8_instruction_execute_tb
// Drives load, execute, tick and row-read items into the CHIP-8 execute block.
// A scoreboard class keeps its own machine state and predicts each result.
// ----------------------------------------------------------------------------
module chip8_instruction_execute_tb;
    import c8ie_pkg::*;

    localparam int MEM_N = MEM_BYTES_DEF;
    localparam int STK_N = STACK_DEPTH_DEF;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] opcode;
        logic [11:0] address;
        logic [7:0]  data;
        logic [15:0] key_mask;
        logic [3:0]  waited_key;
        logic [7:0]  random_byte;
        logic [4:0]  row_index;
    } item_t;

    typedef struct {
        logic        status;
        logic [15:0] next_pc;
        logic [15:0] index_value;
        logic [7:0]  flag_value;
        logic        sound_on;
        logic [63:0] display_row;
    } res_t;

    class chip8_scoreboard;
        logic [7:0]  vr[16];
        logic [15:0] pc, ir;
        logic [15:0] stk[STK_N];
        bit          stk_ok[STK_N];
        int          sp;
        logic [7:0]  dt, st;
        logic [7:0]  mem[MEM_N];
        bit          mem_ok[MEM_N];
        logic [63:0] fb[SCREEN_H];
        res_t        pending[$];
        int          errors;

        function void clear();
            for (int i = 0; i < 16; i++) vr[i] = 0;
            for (int i = 0; i < STK_N; i++) begin
                stk[i] = 0;
                stk_ok[i] = 0;
            end
            for (int i = 0; i < MEM_N; i++) begin
                mem[i] = 0;
                mem_ok[i] = 0;
            end
            for (int i = 0; i < SCREEN_H; i++) fb[i] = 0;
            pc = PC_RESET;
            ir = 0;
            sp = 0;
            dt = 0;
            st = 0;
            errors = 0;
        endfunction

        function void poke(int a, logic [7:0] d);
            mem[a % MEM_N] = d;
            mem_ok[a % MEM_N] = 1;
        endfunction

        // keeps reads of unwritten memory or stack entries from happening
        function void legalize(ref item_t it);
            logic [3:0] x;
            int n;
            if (it.kind != KIND_EXEC) return;
            x = it.opcode[11:8];
            n = -1;
            if (it.opcode[15:12] == 4'hD) n = it.opcode[3:0];
            if (it.opcode[15:12] == 4'hF && it.opcode[7:0] == 8'h65) n = x + 1;
            for (int i = 0; i < n; i++) begin
                if (!mem_ok[(ir + i) % MEM_N]) begin
                    it.kind = KIND_LOAD;
                    it.address = (ir + i) % MEM_N;
                    return;
                end
            end
            if (it.opcode == 16'h00EE && !stk_ok[(sp + STK_N - 1) % STK_N])
                it.opcode = {4'h2, it.opcode[11:0] | 12'h200};
        endfunction

        function void note_item(item_t it);
            res_t r;
            logic [3:0] x, y;
            logic [7:0] vx, vy, nn;
            logic [8:0] sum;
            logic [63:0] m;
            int rot, row;
            bit pressed;
            x = it.opcode[11:8];
            y = it.opcode[7:4];
            nn = it.opcode[7:0];
            vx = vr[x];
            vy = vr[y];
            r.status = 0;
            case (it.kind)
                KIND_LOAD: poke(it.address, it.data);
                KIND_TICK: begin
                    if (dt != 0) dt--;
                    if (st != 0) st--;
                end
                KIND_EXEC: begin
                    pc = pc + 2;
                    case (it.opcode[15:12])
                        4'h0: begin
                            if (it.opcode == 16'h00E0) begin
                                for (int i = 0; i < SCREEN_H; i++) fb[i] = 0;
                            end else if (it.opcode == 16'h00EE) begin
                                sp = (sp + STK_N - 1) % STK_N;
                                pc = stk[sp];
                            end else begin
                                r.status = 1;
                            end
                        end
                        4'h1: pc = it.opcode[11:0];
                        4'h2: begin
                            stk[sp] = pc;
                            stk_ok[sp] = 1;
                            sp = (sp + 1) % STK_N;
                            pc = it.opcode[11:0];
                        end
                        4'h3: if (vx == nn) pc = pc + 2;
                        4'h4: if (vx != nn) pc = pc + 2;
                        4'h5: if (vx == vy) pc = pc + 2;
                        4'h6: vr[x] = nn;
                        4'h7: vr[x] = vx + nn;
                        4'h8: begin
                            case (it.opcode[3:0])
                                4'h0: vr[x] = vy;
                                4'h1: vr[x] = vx | vy;
                                4'h2: vr[x] = vx & vy;
                                4'h3: vr[x] = vx ^ vy;
                                4'h4: begin
                                    sum = vx + vy;
                                    vr[15] = sum[8];
                                    vr[x] = sum[7:0];
                                end
                                4'h5: begin
                                    vr[15] = (vx >= vy);
                                    vr[x] = vx - vy;
                                end
                                4'h6: begin
                                    vr[15] = vx[0];
                                    vr[x] = vx >> 1;
                                end
                                4'h7: begin
                                    vr[15] = (vy >= vx);
                                    vr[x] = vy - vx;
                                end
                                4'hE: begin
                                    vr[15] = vx[7];
                                    vr[x] = vx << 1;
                                end
                                default: r.status = 1;
                            endcase
                        end
                        4'h9: if (vx != vy) pc = pc + 2;
                        4'hA: ir = it.opcode[11:0];
                        4'hB: pc = it.opcode[11:0] + vr[0];
                        4'hC: vr[x] = it.random_byte & nn;
                        4'hD: begin
                            vr[15] = 0;
                            rot = vx % SCREEN_W;
                            for (int i = 0; i < it.opcode[3:0]; i++) begin
                                m = {mem[(ir + i) % MEM_N], 56'b0};
                                if (rot != 0) m = (m >> rot) | (m << (64 - rot));
                                row = (vy + i) % SCREEN_H;
                                if ((fb[row] & m) != 0) vr[15] = 1;
                                fb[row] ^= m;
                            end
                        end
                        4'hE: begin
                            pressed = vx < 16 && it.key_mask[vx[3:0]];
                            if (nn == 8'h9E) begin
                                if (pressed) pc = pc + 2;
                            end else if (nn == 8'hA1) begin
                                if (!pressed) pc = pc + 2;
                            end else begin
                                r.status = 1;
                            end
                        end
                        default: begin
                            case (nn)
                                8'h07: vr[x] = dt;
                                8'h0A: vr[x] = it.waited_key;
                                8'h15: dt = vx;
                                8'h18: st = vx;
                                8'h1E: ir = ir + vx;
                                8'h29: ir = vx * 5;
                                8'h33: begin
                                    poke(ir, vx / 100);
                                    poke(ir + 1, (vx / 10) % 10);
                                    poke(ir + 2, vx % 10);
                                end
                                8'h55: for (int k = 0; k <= x; k++) poke(ir + k, vr[k]);
                                8'h65: for (int k = 0; k <= x; k++) vr[k] = mem[(ir + k) % MEM_N];
                                default: r.status = 1;
                            endcase
                        end
                    endcase
                end
                default: ;
            endcase
            r.next_pc = pc;
            r.index_value = ir;
            r.flag_value = vr[15];
            r.sound_on = (st != 0);
            r.display_row = fb[it.row_index];
            pending.push_back(r);
        endfunction

        function void check_result(res_t a);
            res_t e;
            if (pending.size() == 0) begin
                $display("%0t: result with none expected, pc %h", $time, a.next_pc);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status) begin
                $display("%0t: status exp %h act %h", $time, e.status, a.status);
                errors++;
            end
            if (a.next_pc !== e.next_pc) begin
                $display("%0t: next_pc exp %h act %h", $time, e.next_pc, a.next_pc);
                errors++;
            end
            if (a.index_value !== e.index_value) begin
                $display("%0t: index exp %h act %h", $time, e.index_value, a.index_value);
                errors++;
            end
            if (a.flag_value !== e.flag_value) begin
                $display("%0t: VF exp %h act %h", $time, e.flag_value, a.flag_value);
                errors++;
            end
            if (a.sound_on !== e.sound_on) begin
                $display("%0t: sound exp %h act %h", $time, e.sound_on, a.sound_on);
                errors++;
            end
            if (a.display_row !== e.display_row) begin
                $display("%0t: row exp %h act %h", $time, e.display_row, a.display_row);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_kind;
    logic [15:0] i_opcode;
    logic [11:0] i_address;
    logic [7:0]  i_data;
    logic [15:0] i_key_mask;
    logic [3:0]  i_waited_key;
    logic [7:0]  i_random_byte;
    logic [4:0]  i_row_index;
    logic        o_done;
    logic        o_status;
    logic [15:0] o_next_pc;
    logic [15:0] o_index_value;
    logic [7:0]  o_flag_value;
    logic        o_sound_on;
    logic [63:0] o_display_row;

    chip8_scoreboard sb;

    chip8_instruction_execute u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_opcode      (i_opcode),
        .i_address     (i_address),
        .i_data        (i_data),
        .i_key_mask    (i_key_mask),
        .i_waited_key  (i_waited_key),
        .i_random_byte (i_random_byte),
        .i_row_index   (i_row_index),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_next_pc     (o_next_pc),
        .o_index_value (o_index_value),
        .o_flag_value  (o_flag_value),
        .o_sound_on    (o_sound_on),
        .o_display_row (o_display_row)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(negedge i_clk) begin
        res_t r;
        if (i_rst_n && o_done) begin
            r.status = o_status;
            r.next_pc = o_next_pc;
            r.index_value = o_index_value;
            r.flag_value = o_flag_value;
            r.sound_on = o_sound_on;
            r.display_row = o_display_row;
            sb.check_result(r);
        end
    end

    function automatic item_t rand_fields();
        item_t it;
        it.kind = KIND_EXEC;
        it.opcode = $urandom;
        it.address = $urandom;
        it.data = $urandom;
        it.key_mask = $urandom;
        it.waited_key = $urandom;
        it.random_byte = $urandom_range(0, 254);
        it.row_index = $urandom;
        return it;
    endfunction

    function automatic logic [15:0] rand_opcode();
        logic [15:0] w;
        logic [3:0] lo;
        w = $urandom;
        case ($urandom_range(0, 21))
            0:  w = 16'h00E0;
            1:  w = 16'h00EE;
            2:  w = {4'h2, 4'h2, w[7:0]};
            3:  w = {4'h1, w[11:0]};
            4:  w = {4'h3, w[11:0]};
            5:  w = {4'h4, w[11:0]};
            6:  w = {4'h5, w[11:0]};
            7:  w = {4'h9, w[11:0]};
            8:  w = {4'h6, w[11:0]};
            9:  w = {4'h7, w[11:0]};
            10, 11: begin
                lo = $urandom_range(0, 8);
                w = {4'h8, w[11:4], (lo == 8) ? 4'hE : lo};
            end
            12: w = {4'hA, 4'h3, w[7:0]};
            13: w = {4'hB, w[11:0]};
            14: w = {4'hC, w[11:0]};
            15, 16: w = {4'hD, w[11:4], 4'($urandom_range(0, 6))};
            17: w = {4'hE, w[11:8], ($urandom_range(0, 1) != 0) ? 8'h9E : 8'hA1};
            18, 19: begin
                case ($urandom_range(0, 9))
                    0: w[7:0] = 8'h07;
                    1: w[7:0] = 8'h0A;
                    2: w[7:0] = 8'h15;
                    3: w[7:0] = 8'h18;
                    4: w[7:0] = 8'h1E;
                    5: w[7:0] = 8'h29;
                    6: w[7:0] = 8'h33;
                    7: w[7:0] = 8'h55;
                    8: w[7:0] = 8'h65;
                    default: ;
                endcase
                w[15:12] = 4'hF;
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic send(item_t it);
        sb.legalize(it);
        i_kind        <= it.kind;
        i_opcode      <= it.opcode;
        i_address     <= it.address;
        i_data        <= it.data;
        i_key_mask    <= it.key_mask;
        i_waited_key  <= it.waited_key;
        i_random_byte <= it.random_byte;
        i_row_index   <= it.row_index;
        start         <= 1'b1;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        sb.note_item(it);
    endtask

    task automatic send_op(logic [15:0] op);
        item_t it;
        it = rand_fields();
        it.opcode = op;
        send(it);
    endtask

    task automatic send_kind(logic [1:0] k, logic [11:0] a, logic [7:0] d, logic [4:0] row);
        item_t it;
        it = rand_fields();
        it.kind = k;
        it.address = a;
        it.data = d;
        it.row_index = row;
        send(it);
    endtask

    initial begin
        item_t it;
        int roll;
        sb = new();
        sb.clear();
        i_rst_n = 0;
        start = 0;
        i_kind = 0;
        i_opcode = 0;
        i_address = 0;
        i_data = 0;
        i_key_mask = 0;
        i_waited_key = 0;
        i_random_byte = 0;
        i_row_index = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        send_kind(KIND_LOAD, 12'h300, 8'hFF, 5'd0);
        send_kind(KIND_LOAD, 12'hFFF, 8'h81, 5'd31);
        send_op(16'h60FF);
        send_op(16'h6101);
        send_op(16'h8014);
        send_op(16'h8F15);
        send_op(16'h8017);
        send_op(16'h8F06);
        send_op(16'h80FE);
        send_op(16'hAFFF);
        send_op(16'hD0F2);
        send_op(16'hD0F2);
        send_op(16'hD000);
        send_op(16'hF033);
        send_op(16'hFF55);
        send_op(16'hFF65);
        send_op(16'h2FFF);
        send_op(16'h00EE);
        send_op(16'h0123);
        send_op(16'h800F);
        send_op(16'hE0A1);
        send_op(16'hF018);
        send_kind(KIND_TICK, 12'h0, 8'h0, 5'd31);
        send_op(16'hFFFF);
        send_op(16'h00E0);

        for (int n = 0; n < 1350; n++) begin
            it = rand_fields();
            roll = $urandom_range(0, 99);
            if (roll < 18) begin
                it.kind = KIND_LOAD;
                if ($urandom_range(0, 3) != 0) it.address = 12'h300 | it.address[7:0];
            end else if (roll < 26) begin
                it.kind = KIND_TICK;
            end else if (roll < 31) begin
                it.kind = KIND_READ;
            end else if (roll < 35) begin
                it.opcode = $urandom;
            end else begin
                it.opcode = rand_opcode();
            end
            send(it);
            if (n < 1150 && $urandom_range(0, 3) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
        end
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
